### design/eprm_pkg.sv
// shared types and constants for the encoder period rpm meter
package eprm_pkg;

  localparam int unsigned CLK_HZ_W = 28;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned OVF_W    = 16;
  localparam int unsigned GAP_W    = 32;
  localparam int unsigned NUM_W    = 42;
  localparam int unsigned DEN_W    = 48;
  localparam int unsigned RPM_W    = 41;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned TICK_W   = CLK_HZ_W;
  localparam int unsigned ALIGN_W  = NUM_W - TICK_W;

  localparam logic [STEP_W-1:0] TICK_STEPS = STEP_W'(TICK_W);
  localparam logic [STEP_W-1:0] RPM_STEPS  = STEP_W'(NUM_W);

  localparam logic [CLK_HZ_W-1:0] CLK_HZ_RST     = CLK_HZ_W'(72000000);
  localparam logic [CFG_W-1:0]    PRESC_RST      = CFG_W'(0);
  localparam logic [CFG_W-1:0]    OVF_WEIGHT_RST = CFG_W'(10000);
  localparam logic [CFG_W-1:0]    PPR_RST        = CFG_W'(160);
  localparam logic [OVF_W-1:0]    OVF_MAX        = '1;

  typedef enum logic [1:0] {
    CFG_CLK_HZ     = 2'd0,
    CFG_PRESC      = 2'd1,
    CFG_OVF_WEIGHT = 2'd2,
    CFG_PPR        = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_OVF     = 1'b0,
    CMD_CAPTURE = 1'b1
  } cmd_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PROD = 7'b0000010,
    S_GAP  = 7'b0000100,
    S_DEN  = 7'b0001000,
    S_TICK = 7'b0010000,
    S_NUM  = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### design/eprm_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
module eprm_div import eprm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [NUM_W-1:0] quotient
);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial   = {rem_r, quo_r[NUM_W-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign ge      = ~diff[DEN_W];
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

### design/encoder_period_rpm_meter_top.sv
// two-channel encoder tachometer: period capture to rpm in unsigned q.8
// overflow ticks and first captures complete in the cycle of their transaction
// second capture: result passes S_PROD, S_GAP, S_DEN, S_NUM and the 42-step divider in S_DIV
// after a write to timer_clock_hz or prescaler, the next result first recomputes the tick rate in S_TICK
// input held off while computing and until the result moves to the output register
// rst_n synchronous active low: registers to defaults, both channels armed, counts cleared
module encoder_period_rpm_meter_top import eprm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CAP_W-1:0]    in_tdata,   // [15:0] capture_value
  input  logic [1:0]          in_tuser,   // [0] command, [1] channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,  // [40:0] rpm_q8, [47:41] zero
  output logic [0:0]          out_tuser,  // [0] channel_out
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [CLK_HZ_W-1:0] cfg_wdata
);

  state_t              state_r;
  logic [CLK_HZ_W-1:0] clk_hz_r;
  logic [CFG_W-1:0]    presc_r;
  logic [CFG_W-1:0]    ovw_r;
  logic [CFG_W-1:0]    ppr_r;
  logic                expect_first_r [2];
  logic [OVF_W-1:0]    ovf_cnt_r [2];
  logic                tick_valid_r;
  logic [TICK_W-1:0]   tick_r;
  logic                chan_r;
  logic [CAP_W-1:0]    cap_r;
  logic [OVF_W-1:0]    ovf_r;
  logic [GAP_W-1:0]    prod_r;
  logic [GAP_W-1:0]    gap_r;
  logic [DEN_W-1:0]    den_r;
  logic [RPM_W-1:0]    res_r;
  logic                res_valid_r;
  logic                out_tvalid_r;
  logic                out_chan_r;
  logic [RPM_W-1:0]    out_rpm_r;

  logic                in_fire;
  cmd_t                in_cmd;
  logic                in_chan;
  logic [NUM_W-1:0]    num;
  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [NUM_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic [NUM_W-1:0]    div_quo;
  logic [RPM_W-1:0]    rpm_sat;
  logic                out_free;

  assign in_tready = (state_r == S_IDLE) && !res_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser[0]);
  assign in_chan   = in_tuser[1];
  assign out_free  = !out_tvalid_r || out_tready;

  // tick * 60 * 256 = tick * (2^14 - 2^10)
  assign num = {tick_r, 14'b0} - {4'b0, tick_r, 10'b0};

  assign rpm_sat = div_quo[NUM_W-1] ? '1 : div_quo[RPM_W-1:0];

  always_comb begin
    div_ctl      = '0;
    div_dividend = num;
    div_divisor  = den_r;
    unique case (state_r)
      S_DEN: begin
        div_ctl.start = !tick_valid_r;
        div_ctl.steps = TICK_STEPS;
        div_dividend  = {clk_hz_r, ALIGN_W'(0)};
        div_divisor   = DEN_W'({1'b0, presc_r} + 17'd1);
      end
      S_NUM: begin
        div_ctl.start = (den_r != '0);
        div_ctl.steps = RPM_STEPS;
      end
      default: begin
      end
    endcase
  end

  eprm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      clk_hz_r          <= CLK_HZ_RST;
      presc_r           <= PRESC_RST;
      ovw_r             <= OVF_WEIGHT_RST;
      ppr_r             <= PPR_RST;
      expect_first_r[0] <= 1'b1;
      expect_first_r[1] <= 1'b1;
      ovf_cnt_r[0]      <= '0;
      ovf_cnt_r[1]      <= '0;
      tick_valid_r      <= 1'b0;
      res_valid_r       <= 1'b0;
      out_tvalid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_CLK_HZ: begin
            clk_hz_r     <= cfg_wdata;
            tick_valid_r <= 1'b0;
          end
          CFG_PRESC: begin
            presc_r      <= cfg_wdata[CFG_W-1:0];
            tick_valid_r <= 1'b0;
          end
          CFG_OVF_WEIGHT: ovw_r <= cfg_wdata[CFG_W-1:0];
          CFG_PPR:        ppr_r <= cfg_wdata[CFG_W-1:0];
        endcase
      end

      if (in_fire) begin
        if (in_cmd == CMD_OVF) begin
          if (ovf_cnt_r[in_chan] != OVF_MAX) begin
            ovf_cnt_r[in_chan] <= ovf_cnt_r[in_chan] + OVF_W'(1);
          end
        end else if (expect_first_r[in_chan]) begin
          expect_first_r[in_chan] <= 1'b0;
        end else begin
          expect_first_r[in_chan] <= 1'b1;
          ovf_cnt_r[in_chan]      <= '0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_cmd == CMD_CAPTURE && !expect_first_r[in_chan]) begin
            state_r <= S_PROD;
          end
        end
        S_PROD: state_r <= S_GAP;
        S_GAP:  state_r <= S_DEN;
        S_DEN:  state_r <= tick_valid_r ? S_NUM : S_TICK;
        S_TICK: begin
          if (div_sts.done) begin
            tick_valid_r <= 1'b1;
            state_r      <= S_NUM;
          end
        end
        S_NUM: begin
          if (den_r == '0) begin
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (res_valid_r && out_free) begin
        res_valid_r  <= 1'b0;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      chan_r <= in_chan;
      cap_r  <= in_tdata;
      ovf_r  <= ovf_cnt_r[in_chan];
    end
    if (state_r == S_PROD) begin
      prod_r <= ovw_r * ovf_r;
    end
    if (state_r == S_GAP) begin
      gap_r <= prod_r + GAP_W'(cap_r);
    end
    if (state_r == S_DEN) begin
      den_r <= gap_r * ppr_r;
    end
    if (state_r == S_TICK && div_sts.done) begin
      tick_r <= div_quo[TICK_W-1:0];
    end
    if (state_r == S_NUM && den_r == '0) begin
      res_r <= '0;
    end else if (state_r == S_DIV && div_sts.done) begin
      res_r <= rpm_sat;
    end
    if (res_valid_r && out_free) begin
      out_chan_r <= chan_r;
      out_rpm_r  <= res_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_rpm_r};
  assign out_tuser  = out_chan_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_num_tick_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NUM) |-> tick_valid_r)
    else $error("rpm division without a valid tick rate");

  a_second_capture_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_CAPTURE && !expect_first_r[in_chan])
      |=> (state_r == S_PROD) && expect_first_r[chan_r] && (ovf_cnt_r[chan_r] == '0))
    else $error("second capture did not start the computation and rearm");

  a_div_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_sts.done) |=> res_valid_r && (state_r == S_IDLE))
    else $error("division result not captured");

  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_sts.busy)
    else $error("input ready while divider busy");
`endif

endmodule
